FILE: sv/scancode_line_assembler_macros.svh
// Assertion macros for the line assembler; scl_back uses them.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef SCANCODE_LINE_ASSEMBLER_MACROS_SVH
`define SCANCODE_LINE_ASSEMBLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/scl_pkg.sv
// Shared types, constants and the scancode map for the line assembler.
// Depends on nothing; every other file of the block but the macro header uses it.
`default_nettype none

package scl_pkg;

	// Line store depth; at most LINE_DEPTH-1 characters are held.
	localparam int LINE_DEPTH = 64;
	localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	// Depth of the command queue between the front and the back.
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	localparam logic [7:0] CODE_RELEASE   = 8'h80;
	localparam logic [7:0] CODE_ENTER     = 8'h1C;
	localparam logic [7:0] CODE_BACKSPACE = 8'h0E;

	localparam logic [6:0] CHAR_NONE = 7'h00;
	localparam logic [6:0] CHAR_BS   = 7'h08;
	localparam logic [6:0] CHAR_LF   = 7'h0A;

	localparam logic [1:0] KIND_ECHO      = 2'd0;
	localparam logic [1:0] KIND_ERASE     = 2'd1;
	localparam logic [1:0] KIND_LINE_CHAR = 2'd2;
	localparam logic [1:0] KIND_LINE_END  = 2'd3;

	typedef enum logic [1:0] {
		OP_CHAR,
		OP_ERASE,
		OP_ENTER
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] ch;
	} cmd_t;

	// US set-1 map; zero means the code produces no character.
	function automatic logic [6:0] us_map(input logic [7:0] code);
		logic [6:0] ch;
		ch = CHAR_NONE;
		case (code)
			8'd2:    ch = 7'h31; // 1
			8'd3:    ch = 7'h32;
			8'd4:    ch = 7'h33;
			8'd5:    ch = 7'h34;
			8'd6:    ch = 7'h35;
			8'd7:    ch = 7'h36;
			8'd8:    ch = 7'h37;
			8'd9:    ch = 7'h38;
			8'd10:   ch = 7'h39; // 9
			8'd11:   ch = 7'h30; // 0
			8'd12:   ch = 7'h2D; // -
			8'd13:   ch = 7'h3D; // =
			8'd14:   ch = CHAR_BS;
			8'd15:   ch = 7'h09; // tab
			8'd16:   ch = 7'h71; // q
			8'd17:   ch = 7'h77; // w
			8'd18:   ch = 7'h65; // e
			8'd19:   ch = 7'h72; // r
			8'd20:   ch = 7'h74; // t
			8'd21:   ch = 7'h79; // y
			8'd22:   ch = 7'h75; // u
			8'd23:   ch = 7'h69; // i
			8'd24:   ch = 7'h6F; // o
			8'd25:   ch = 7'h70; // p
			8'd26:   ch = 7'h5B; // [
			8'd27:   ch = 7'h5D; // ]
			8'd28:   ch = CHAR_LF;
			8'd30:   ch = 7'h61; // a
			8'd31:   ch = 7'h73; // s
			8'd32:   ch = 7'h64; // d
			8'd33:   ch = 7'h66; // f
			8'd34:   ch = 7'h67; // g
			8'd35:   ch = 7'h68; // h
			8'd36:   ch = 7'h6A; // j
			8'd37:   ch = 7'h6B; // k
			8'd38:   ch = 7'h6C; // l
			8'd39:   ch = 7'h3B; // ;
			8'd40:   ch = 7'h27; // quote
			8'd41:   ch = 7'h60; // backtick
			8'd43:   ch = 7'h5C; // backslash
			8'd44:   ch = 7'h7A; // z
			8'd45:   ch = 7'h78; // x
			8'd46:   ch = 7'h63; // c
			8'd47:   ch = 7'h76; // v
			8'd48:   ch = 7'h62; // b
			8'd49:   ch = 7'h6E; // n
			8'd50:   ch = 7'h6D; // m
			8'd51:   ch = 7'h2C; // ,
			8'd52:   ch = 7'h2E; // .
			8'd53:   ch = 7'h2F; // /
			8'd55:   ch = 7'h2A; // *
			8'd57:   ch = 7'h20; // space
			default: ch = CHAR_NONE;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

FILE: sv/scancode_line_assembler.sv
// Top level of the scancode line assembler: front classifier, command queue and back executor.
// Depends on scl_pkg, scl_front, scl_cmd_fifo and scl_back.
`default_nettype none

// The block turns raw set-1 scancodes into a small line editor. Release codes, unmapped
// codes and codes past the US map are swallowed. A printable key is stored and echoed while
// the line holds fewer than LINE_DEPTH-1 characters. Backspace drops the last character and
// gives an erase echo, or nothing on an empty line. Enter replays the stored line as line
// characters followed by a line-end result flagged last, then clears the line. Both sides
// behave like a queue: a scancode transfer happens when push is high and full is low, a
// result transfer when pop is high and empty is low. A keystroke moves through the front
// register, then the command queue; an echo or erase result appears in the cycle after the
// back takes the command. An Enter holds the back for the replay, as the line memory has
// one read port and yields one character per cycle unless the result side stalls; meanwhile
// the front keeps taking keystrokes until the four-entry command queue and its own register
// are full. A stalled result side holds the back, and through the queue the front.
module scancode_line_assembler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic [7:0]  scancode,
	output logic             full,
	input  wire logic        pop,
	output logic             empty,
	output logic [1:0]       kind,
	output logic [6:0]       character,
	output logic             last
);

	// Command transfer from the front register into the queue.
	logic          q_push;
	logic          q_full;
	scl_pkg::cmd_t q_cmd;

	// Command transfer from the queue head into the back.
	logic          head_valid;
	logic          head_pop;
	scl_pkg::cmd_t head_cmd;

	scl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.scancode (scancode),
		.full     (full),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	scl_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (head_pop),
		.head_cmd  (head_cmd),
		.not_empty (head_valid)
	);

	// The back owns the line memory and the result register.
	scl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (head_cmd),
		.cmd_pop   (head_pop),
		.pop       (pop),
		.empty     (empty),
		.kind      (kind),
		.character (character),
		.last      (last)
	);

endmodule

`default_nettype wire

FILE: sv/scl_front.sv
// Front end of the line assembler: takes scancodes and classifies them into commands.
// Depends on scl_pkg.
`default_nettype none

module scl_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [7:0]    scancode,
	output logic               full,
	input  wire logic          q_full,
	output logic               q_push,
	output scl_pkg::cmd_t      q_cmd
);

	logic          valid_s1;
	scl_pkg::cmd_t cmd_s1;
	scl_pkg::cmd_t cls;
	logic          keep;
	logic          take;
	logic [6:0]    mapped;

	// Releases, unmapped codes and codes past the map are dropped right here.
	always_comb begin
		mapped  = scl_pkg::us_map(scancode);
		cls.op  = scl_pkg::OP_CHAR;
		cls.ch  = mapped;
		keep    = 1'b0;
		if ((scancode & scl_pkg::CODE_RELEASE) != 8'h00) begin
			keep = 1'b0;
		end else if (scancode == scl_pkg::CODE_ENTER) begin
			cls.op = scl_pkg::OP_ENTER;
			cls.ch = scl_pkg::CHAR_NONE;
			keep   = 1'b1;
		end else if (scancode == scl_pkg::CODE_BACKSPACE) begin
			cls.op = scl_pkg::OP_ERASE;
			cls.ch = scl_pkg::CHAR_NONE;
			keep   = 1'b1;
		end else begin
			keep = (mapped != scl_pkg::CHAR_NONE);
		end
	end

	assign q_push = valid_s1 && !q_full;
	assign full   = valid_s1 && q_full;
	assign take   = push && !full;
	assign q_cmd  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= keep;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cls;
		end
	end

endmodule

`default_nettype wire

FILE: sv/scl_cmd_fifo.sv
// Short command queue between the front and the back of the line assembler.
// Depends on scl_pkg.
`default_nettype none

module scl_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire scl_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output scl_pkg::cmd_t      head_cmd,
	output logic               not_empty
);

	scl_pkg::cmd_t                   slots_q [scl_pkg::CMD_DEPTH];
	logic [scl_pkg::CMD_PTR_W-1:0]   wr_ptr_q;
	logic [scl_pkg::CMD_PTR_W-1:0]   rd_ptr_q;
	logic [scl_pkg::CMD_CNT_W-1:0]   count_q;
	logic                            do_push;
	logic                            do_pop;

	assign full      = (count_q == scl_pkg::CMD_CNT_W'(scl_pkg::CMD_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_cmd  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

FILE: sv/scl_back.sv
// Back end of the line assembler: keeps the line, executes commands and drives results.
// Depends on scl_pkg and scancode_line_assembler_macros.svh.
`default_nettype none
`include "scancode_line_assembler_macros.svh"

module scl_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire scl_pkg::cmd_t cmd,
	output logic               cmd_pop,
	input  wire logic          pop,
	output logic               empty,
	output logic [1:0]         kind,
	output logic [6:0]         character,
	output logic               last
);

	localparam logic [scl_pkg::ADDR_W-1:0] LEN_MAX =
		scl_pkg::ADDR_W'(scl_pkg::LINE_DEPTH - 1);

	typedef enum logic {
		ST_IDLE,
		ST_REPLAY
	} state_t;

	state_t                      state_q;
	logic [scl_pkg::ADDR_W-1:0]  len_q;
	logic [scl_pkg::ADDR_W-1:0]  rd_idx_q;
	logic                        rd_vld_q;
	logic [6:0]                  rdata_q;
	logic                        out_valid_q;
	logic [1:0]                  kind_q;
	logic [6:0]                  char_q;
	logic                        last_q;
	logic [6:0]                  line_mem [scl_pkg::LINE_DEPTH];

	logic out_free;
	logic emit_char;
	logic rd_issue;
	logic end_emit;
	logic cmd_take;
	logic echo_emit;
	logic erase_emit;

	always_comb begin
		out_free   = !out_valid_q || pop;
		emit_char  = (state_q == ST_REPLAY) && rd_vld_q && out_free;
		rd_issue   = (state_q == ST_REPLAY) && (rd_idx_q != len_q) &&
		             (!rd_vld_q || emit_char);
		end_emit   = (state_q == ST_REPLAY) && (rd_idx_q == len_q) && !rd_vld_q && out_free;
		cmd_take   = (state_q == ST_IDLE) && cmd_valid &&
		             ((cmd.op == scl_pkg::OP_ENTER) || out_free);
		echo_emit  = cmd_take && (cmd.op == scl_pkg::OP_CHAR) && (len_q < LEN_MAX);
		erase_emit = cmd_take && (cmd.op == scl_pkg::OP_ERASE) && (len_q != '0);
	end

	assign cmd_pop   = cmd_take;
	assign empty     = !out_valid_q;
	assign kind      = kind_q;
	assign character = char_q;
	assign last      = last_q;

	// Line memory: written by appends, read one entry per cycle during replay unless results stall.
	always_ff @(posedge clk) begin
		if (echo_emit) begin
			line_mem[len_q] <= cmd.ch;
		end
		if (rd_issue) begin
			rdata_q <= line_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			rd_idx_q    <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= scl_pkg::KIND_ECHO;
			char_q      <= scl_pkg::CHAR_NONE;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (echo_emit) begin
						len_q       <= len_q + 1'b1;
						out_valid_q <= 1'b1;
						kind_q      <= scl_pkg::KIND_ECHO;
						char_q      <= cmd.ch;
						last_q      <= 1'b1;
					end else if (erase_emit) begin
						len_q       <= len_q - 1'b1;
						out_valid_q <= 1'b1;
						kind_q      <= scl_pkg::KIND_ERASE;
						char_q      <= scl_pkg::CHAR_NONE;
						last_q      <= 1'b1;
					end else if (cmd_take && (cmd.op == scl_pkg::OP_ENTER)) begin
						rd_idx_q <= '0;
						rd_vld_q <= 1'b0;
						state_q  <= ST_REPLAY;
					end
				end
				ST_REPLAY: begin
					if (rd_issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						rd_vld_q <= 1'b1;
					end else if (emit_char) begin
						rd_vld_q <= 1'b0;
					end
					if (emit_char) begin
						out_valid_q <= 1'b1;
						kind_q      <= scl_pkg::KIND_LINE_CHAR;
						char_q      <= rdata_q;
						last_q      <= 1'b0;
					end
					if (end_emit) begin
						out_valid_q <= 1'b1;
						kind_q      <= scl_pkg::KIND_LINE_END;
						char_q      <= scl_pkg::CHAR_NONE;
						last_q      <= 1'b1;
						len_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SCL_ASSERT_NOW(a_len_bound, 1'b1, len_q <= LEN_MAX, "line length beyond store capacity")
	`SCL_ASSERT_NOW(a_rd_idx_bound, state_q == ST_REPLAY, rd_idx_q <= len_q, "replay index past line end")
	`SCL_ASSERT_NOW(a_rd_vld_replay, rd_vld_q, state_q == ST_REPLAY, "read data pending outside replay")
	`SCL_ASSERT_NEXT(a_end_clears, end_emit, (len_q == '0) && (state_q == ST_IDLE), "line not cleared after line end")

endmodule

`default_nettype wire

FILE: dv/scl_line_checker.sv
// Scoreboard for the scancode line assembler: predicts the result stream from the accepted
// scancodes and compares every accepted result with it. Depends on scl_pkg for the codes.
module scl_line_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] scancode,
	input  wire logic       full,
	input  wire logic       pop,
	input  wire logic       empty,
	input  wire logic [1:0] kind,
	input  wire logic [6:0] character,
	input  wire logic       last,
	output int              errors,
	output int              owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] ch;
		logic       last;
	} line_result_t;

	// US set-1 keys, indexed by scancode; zero marks a key with no character.
	localparam logic [6:0] KEY_TO_ASCII [0:57] = '{
		7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
		7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	logic [6:0]   typed_chars [scl_pkg::LINE_DEPTH];
	int           typed_len;
	line_result_t owed_results [$];
	int           mismatches;

	assign errors = mismatches;

	// Updates the line copy for one scancode and queues the results it owes.
	task automatic apply_scancode(input logic [7:0] code);
		logic [6:0] ch;
		if (code[7]) begin
			return;
		end
		if (code == scl_pkg::CODE_ENTER) begin
			for (int i = 0; i < typed_len; i++)
				owed_results.push_back(line_result_t'{scl_pkg::KIND_LINE_CHAR,
					typed_chars[i], 1'b0});
			owed_results.push_back(line_result_t'{scl_pkg::KIND_LINE_END,
				scl_pkg::CHAR_NONE, 1'b1});
			typed_len = 0;
		end else if (code == scl_pkg::CODE_BACKSPACE) begin
			if (typed_len != 0) begin
				typed_len--;
				owed_results.push_back(line_result_t'{scl_pkg::KIND_ERASE,
					scl_pkg::CHAR_NONE, 1'b1});
			end
		end else if (code < 8'd58) begin
			ch = KEY_TO_ASCII[code];
			if (ch != scl_pkg::CHAR_NONE && typed_len < scl_pkg::LINE_DEPTH - 1) begin
				typed_chars[typed_len] = ch;
				typed_len++;
				owed_results.push_back(line_result_t'{scl_pkg::KIND_ECHO, ch, 1'b1});
			end
		end
	endtask

	task automatic compare_field(input string field, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_result_t want;
		if (!arst_n) begin
			owed_results.delete();
			typed_len = 0;
			mismatches = 0;
			owed <= 0;
		end else begin
			if (push && !full)
				apply_scancode(scancode);
			if (pop && !empty) begin
				if (owed_results.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected result, expected none, actual kind %0d char %0d last %0d",
						$time, kind, character, last);
				end else begin
					want = owed_results.pop_front();
					compare_field("kind", want.kind, kind);
					compare_field("character", want.ch, character);
					compare_field("last", want.last, last);
				end
			end
			owed <= owed_results.size();
		end
	end

endmodule

FILE: dv/tb.sv
// Testbench top for the scancode line assembler: clock, reset, keystroke stimulus and verdict.
// Depends on scl_pkg, the block itself and the scl_line_checker scoreboard.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Scancodes used by name in the stimulus. Keys the US map leaves without a character
	// are listed so that the random typing can steer around them.
	localparam logic [7:0] KEY_NONE      = 8'h00;
	localparam logic [7:0] KEY_ESC       = 8'h01;
	localparam logic [7:0] KEY_1         = 8'h02;
	localparam logic [7:0] KEY_TAB       = 8'h0F;
	localparam logic [7:0] KEY_Q         = 8'h10;
	localparam logic [7:0] KEY_LCTRL     = 8'h1D;
	localparam logic [7:0] KEY_A         = 8'h1E;
	localparam logic [7:0] KEY_LSHIFT    = 8'h2A;
	localparam logic [7:0] KEY_BSLASH    = 8'h2B;
	localparam logic [7:0] KEY_RSHIFT    = 8'h36;
	localparam logic [7:0] KEY_KP_STAR   = 8'h37;
	localparam logic [7:0] KEY_LALT      = 8'h38;
	localparam logic [7:0] KEY_SPACE     = 8'h39;
	localparam logic [7:0] KEY_CAPS      = 8'h3A;
	localparam logic [7:0] KEY_MAX_PRESS = 8'h7F;

	localparam int KEYSTROKE_GOAL = 220;
	localparam int PHASES         = 4;
	localparam int HOLD_CYCLES    = 200;
	localparam int SETTLE_CYCLES  = 8;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       push     = 1'b0;
	logic [7:0] scancode = 8'h00;
	logic       pop      = 1'b0;
	logic       full;
	logic       empty;
	logic [1:0] kind;
	logic [6:0] character;
	logic       last;

	int errors;
	int owed;

	// Idle and stall odds in percent, the long receiver hold-off request and its state.
	int   idle_pct  = 0;
	int   stall_pct = 0;
	logic hold_req  = 1'b0;
	logic pop_hold  = 1'b0;

	// Scancodes transferred into the block so far, releases and stray bytes included.
	int keystrokes = 0;

	scancode_line_assembler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.scancode  (scancode),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.kind      (kind),
		.character (character),
		.last      (last)
	);

	scl_line_checker i_line_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.scancode  (scancode),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.kind      (kind),
		.character (character),
		.last      (last),
		.errors    (errors),
		.owed      (owed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The result side pops at random, except while the long hold-off is running.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= !pop_hold && ($urandom_range(99) >= stall_pct);
		end
	end

	// Once asked, the receiver refuses results for a long stretch. The sender keeps offering
	// keystrokes meanwhile, so the command queue and the front register fill and full rises.
	initial begin
		while (!hold_req)
			@(posedge clk);
		pop_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		pop_hold <= 1'b0;
	end

	// This bound is far beyond the slowest correct run, including long replays under heavy stalling.
	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// True for a scancode that the map turns into a character stored in the line.
	function automatic bit is_plain_key(input logic [7:0] code);
		case (code)
			KEY_NONE, KEY_ESC, scl_pkg::CODE_BACKSPACE, scl_pkg::CODE_ENTER, KEY_LCTRL,
			KEY_LSHIFT, KEY_RSHIFT, KEY_LALT: return 1'b0;
			default: return code < KEY_CAPS;
		endcase
	endfunction

	// Offers one scancode and returns at the edge where it transfers. Push is left high so
	// that back-to-back keystrokes stream without a bubble; idling lowers it.
	task automatic send_code(input logic [7:0] code);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push     <= 1'b1;
		scancode <= code;
		do
			@(posedge clk);
		while (full);
		keystrokes++;
	endtask

	// Stops sending and waits until every owed result has been popped, then lets the block
	// settle in case a last keystroke with no result is still in flight.
	task automatic drain_results();
		push <= 1'b0;
		do
			@(posedge clk);
		while (owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A press of a random character key, often followed by its release code.
	task automatic type_key();
		logic [7:0] code;
		do
			code = 8'($urandom_range(57));
		while (!is_plain_key(code));
		send_code(code);
		if ($urandom_range(99) < 35)
			send_code(code | scl_pkg::CODE_RELEASE);
	endtask

	// One edited line. A short line mixes typing with backspaces and the odd stray byte; a
	// long one types to the line limit or past it, so that the full-line case and the longest
	// replay are reached. Most lines end with Enter, some carry over into the next line.
	task automatic type_line(input bit long_line);
		int n;
		int r;
		n = long_line ? $urandom_range(63, 68) : $urandom_range(0, 12);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (!long_line && r < 15) begin
				send_code(scl_pkg::CODE_BACKSPACE);
			end else if (!long_line && r < 25) begin
				send_code(8'($urandom_range(255)));
			end else begin
				type_key();
			end
		end
		if (long_line && $urandom_range(1)) begin
			// Free one slot at the limit and fill it again.
			send_code(scl_pkg::CODE_BACKSPACE);
			type_key();
		end
		if ($urandom_range(99) < 85) begin
			send_code(scl_pkg::CODE_ENTER);
			if ($urandom_range(1))
				send_code(scl_pkg::CODE_ENTER | scl_pkg::CODE_RELEASE);
		end
	endtask

	initial begin
		logic [7:0] directed [$];
		int lines;

		// Reset is asserted from time zero, released once and never asserted again.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed keystrokes, no idling: Enter and Backspace on an empty line, release codes
		// including the all-ones byte, dead keys and codes past the map, the first and last
		// mapped keys, erasing down to empty and past it, and Enter on a stored line.
		directed = '{scl_pkg::CODE_ENTER, scl_pkg::CODE_BACKSPACE, KEY_NONE, 8'hFF,
			scl_pkg::CODE_RELEASE, KEY_ESC, KEY_LCTRL, KEY_LSHIFT, KEY_RSHIFT, KEY_LALT,
			KEY_CAPS, KEY_MAX_PRESS, KEY_1, KEY_SPACE, KEY_Q, KEY_BSLASH, KEY_TAB,
			KEY_KP_STAR, scl_pkg::CODE_BACKSPACE,
			scl_pkg::CODE_ENTER | scl_pkg::CODE_RELEASE, scl_pkg::CODE_ENTER, KEY_A,
			scl_pkg::CODE_BACKSPACE, scl_pkg::CODE_BACKSPACE, scl_pkg::CODE_ENTER};
		foreach (directed[i])
			send_code(directed[i]);
		drain_results();

		// Random lines in four phases: no idling, sender idling, receiver stalling with the
		// long hold-off at its start, then both. Each phase ends with the sender pausing
		// until the block has returned everything it owes.
		lines = 0;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct <= 0;  end
				1: begin idle_pct = 51; stall_pct <= 0;  end
				2: begin idle_pct = 0;  stall_pct <= 51; hold_req <= 1'b1; end
				default: begin idle_pct = 38; stall_pct <= 38; end
			endcase
			while (keystrokes < (phase + 1) * KEYSTROKE_GOAL / PHASES) begin
				type_line(lines == 0 || $urandom_range(7) == 0);
				lines++;
			end
			drain_results();
		end

		if (errors == 0 && owed == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/scl_pkg.sv
sv/scl_front.sv
sv/scl_cmd_fifo.sv
sv/scl_back.sv
sv/scancode_line_assembler.sv
dv/scl_line_checker.sv
dv/tb.sv
